>>> rtl/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared constants and width helpers for the segment closest-points pipeline.
// ----------------------------------------------------------------------------
package spcp_pkg;

    localparam int unsigned COORD_BITS_DEF = 16;
    localparam int unsigned FRAC_BITS_DEF  = 16;

    // Width of the determinant terms and divider operands (signed).
    function automatic int unsigned div_width(input int unsigned coord_bits);
        return 4 * coord_bits + 7;
    endfunction

    // Width of one packed half of the geometry sideband: start point and edge.
    function automatic int unsigned side_width(input int unsigned coord_bits);
        return 4 * coord_bits + 2;
    endfunction

endpackage

>>> rtl/spcp_if.sv
// ----------------------------------------------------------------------------
// spcp_in_if / spcp_out_if
// Valid/ready channels carrying a segment pair and its closest-point result.
// ----------------------------------------------------------------------------
interface spcp_in_if #(
    parameter int unsigned COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;

    modport source (
        output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        input  ready
    );
    modport sink (
        input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        output ready
    );
endinterface

interface spcp_out_if #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic [FRAC_BITS:0]           param_s;
    logic [FRAC_BITS:0]           param_t;
    logic signed [COORD_BITS-1:0] near1_x;
    logic signed [COORD_BITS-1:0] near1_y;
    logic signed [COORD_BITS-1:0] near2_x;
    logic signed [COORD_BITS-1:0] near2_y;
    logic [2*COORD_BITS:0]        dist_squared;

    modport source (
        output valid, param_s, param_t, near1_x, near1_y, near2_x, near2_y,
               dist_squared,
        input  ready
    );
    modport sink (
        input  valid, param_s, param_t, near1_x, near1_y, near2_x, near2_y,
               dist_squared,
        output ready
    );
endinterface

>>> rtl/segment_pair_closest_points.sv
// ----------------------------------------------------------------------------
// segment_pair_closest_points
// Closest points, clamped parameters and squared distance of two 2D segments.
//
//   channel   dir  handshake     payload
//   i_seg     in   valid/ready   two segments, start and end points
//   o_res     out  valid/ready   s, t, two closest points, squared distance
//
// One transaction per cycle sustained while o_res is not stalled; the path
// has 7 front stages, FRAC_BITS + 3 divider stages and 5 back stages.
// The divider, one quotient bit per stage, sets the depth.
// Synchronous active-low reset empties the pipeline.
// Every stage holds while the one after it is full and stalled; bubbles
// collapse, so input is taken while a finished result waits at o_res.
// ----------------------------------------------------------------------------
module segment_pair_closest_points #(
    parameter int unsigned COORD_BITS = spcp_pkg::COORD_BITS_DEF,
    parameter int unsigned FRAC_BITS  = spcp_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spcp_in_if.sink       i_seg,
    spcp_out_if.source    o_res
);
    import spcp_pkg::*;

    localparam int unsigned NW = div_width(COORD_BITS);
    localparam int unsigned HW = side_width(COORD_BITS);

    logic                 front_valid, front_adv;
    logic signed [NW-1:0] sn, sd, tn, td;
    logic [HW-1:0]        side_s, side_t, div_side_s, div_side_t;
    logic                 div_valid, div_adv, div_t_valid;
    logic                 back_adv;
    logic [FRAC_BITS:0]   div_s, div_t;

    spcp_front #(
        .COORD_BITS (COORD_BITS),
        .NW         (NW),
        .HW         (HW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_seg.valid),
        .o_adv_in (i_seg.ready),
        .i_p0x    (i_seg.seg1_start_x),
        .i_p0y    (i_seg.seg1_start_y),
        .i_p1x    (i_seg.seg1_end_x),
        .i_p1y    (i_seg.seg1_end_y),
        .i_q0x    (i_seg.seg2_start_x),
        .i_q0y    (i_seg.seg2_start_y),
        .i_q1x    (i_seg.seg2_end_x),
        .i_q1y    (i_seg.seg2_end_y),
        .o_valid  (front_valid),
        .i_adv    (front_adv),
        .o_sn     (sn),
        .o_sd     (sd),
        .o_tn     (tn),
        .o_td     (td),
        .o_side_s (side_s),
        .o_side_t (side_t)
    );

    // both dividers see the same valid/advance, so they stay in lockstep
    spcp_div #(
        .NW        (NW),
        .FRAC_BITS (FRAC_BITS),
        .SBW       (HW)
    ) u_div_s (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .o_adv_in (front_adv),
        .i_n      (sn),
        .i_m      (sd),
        .i_side   (side_s),
        .o_valid  (div_valid),
        .i_adv    (back_adv),
        .o_q      (div_s),
        .o_side   (div_side_s)
    );

    spcp_div #(
        .NW        (NW),
        .FRAC_BITS (FRAC_BITS),
        .SBW       (HW)
    ) u_div_t (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (front_valid),
        .o_adv_in (div_adv),
        .i_n      (tn),
        .i_m      (td),
        .i_side   (side_t),
        .o_valid  (div_t_valid),
        .i_adv    (back_adv),
        .o_q      (div_t),
        .o_side   (div_side_t)
    );

    spcp_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .HW         (HW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .o_adv_in (back_adv),
        .i_s      (div_s),
        .i_t      (div_t),
        .i_side_s (div_side_s),
        .i_side_t (div_side_t),
        .o_valid  (o_res.valid),
        .i_adv    (o_res.ready),
        .o_s      (o_res.param_s),
        .o_t      (o_res.param_t),
        .o_n1x    (o_res.near1_x),
        .o_n1y    (o_res.near1_y),
        .o_n2x    (o_res.near2_x),
        .o_n2y    (o_res.near2_y),
        .o_dist   (o_res.dist_squared)
    );

    // parameters never exceed one
    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.param_s <= {1'b1, {FRAC_BITS{1'b0}}})
                     && (o_res.param_t <= {1'b1, {FRAC_BITS{1'b0}}}))
        else $error("param out of range");

    // input backpressure only when the output holds a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_seg.ready |-> (o_res.valid && !o_res.ready))
        else $error("input stalled without output stall");

    // the two divider lanes never drift apart
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_adv == front_adv) && (div_t_valid == div_valid))
        else $error("divider lanes out of step");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("output valid after reset");

endmodule

>>> rtl/spcp_front.sv
// ----------------------------------------------------------------------------
// spcp_front
// Edge vectors, dot products, determinant terms and the clamp branches.
// Seven register stages; produces numerator/denominator pairs for s and t.
// ----------------------------------------------------------------------------
module spcp_front #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned NW         = 71,
    parameter int unsigned HW         = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_adv_in,
    input  logic signed [COORD_BITS-1:0] i_p0x,
    input  logic signed [COORD_BITS-1:0] i_p0y,
    input  logic signed [COORD_BITS-1:0] i_p1x,
    input  logic signed [COORD_BITS-1:0] i_p1y,
    input  logic signed [COORD_BITS-1:0] i_q0x,
    input  logic signed [COORD_BITS-1:0] i_q0y,
    input  logic signed [COORD_BITS-1:0] i_q1x,
    input  logic signed [COORD_BITS-1:0] i_q1y,
    output logic                         o_valid,
    input  logic                         i_adv,
    output logic signed [NW-1:0]         o_sn,
    output logic signed [NW-1:0]         o_sd,
    output logic signed [NW-1:0]         o_tn,
    output logic signed [NW-1:0]         o_td,
    output logic [HW-1:0]                o_side_s,
    output logic [HW-1:0]                o_side_t
);
    import spcp_pkg::*;

    localparam int unsigned NS = 7;
    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned PW = 2 * COORD_BITS + 2;
    localparam int unsigned SW = 2 * COORD_BITS + 3;
    localparam int unsigned QW = 4 * COORD_BITS + 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;
    logic [2*HW-1:0] r_side [0:NS-1];

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_adv;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_adv_in = adv[0];
    assign o_valid  = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: edge vectors
    logic signed [DW-1:0] n1_ux, n1_uy, n1_vx, n1_vy;
    logic signed [DW-1:0] r1_ux, r1_uy, r1_vx, r1_vy, r1_wx, r1_wy;

    assign n1_ux = DW'(i_p1x) - DW'(i_p0x);
    assign n1_uy = DW'(i_p1y) - DW'(i_p0y);
    assign n1_vx = DW'(i_q1x) - DW'(i_q0x);
    assign n1_vy = DW'(i_q1y) - DW'(i_q0y);

    // stage 2: component products
    logic signed [PW-1:0] r2_uu_x, r2_uu_y, r2_uv_x, r2_uv_y, r2_vv_x, r2_vv_y;
    logic signed [PW-1:0] r2_uw_x, r2_uw_y, r2_vw_x, r2_vw_y;

    // stage 3: dot products
    logic signed [SW-1:0] r3_a, r3_b, r3_c, r3_d, r3_e;

    // stage 4: cross terms
    logic signed [QW-1:0] r4_ac, r4_bb, r4_be, r4_cd, r4_ae, r4_bd;
    logic signed [SW-1:0] r4_a, r4_b, r4_c, r4_d, r4_e;

    // stage 5: determinant and unclamped numerators
    logic signed [NW-1:0] r5_den, r5_sn, r5_tn;
    logic signed [SW-1:0] r5_a, r5_b, r5_c, r5_d, r5_e;

    // stage 6: clamp of s
    logic signed [NW-1:0] n6_sn, n6_sd, n6_tn, n6_td;
    logic signed [NW-1:0] r6_sn, r6_sd, r6_tn, r6_td, r6_nd, r6_nbd, r6_a;

    // stage 7: clamp of t
    logic signed [NW-1:0] n7_sn, n7_sd, n7_tn, n7_td;
    logic signed [NW-1:0] r7_sn, r7_sd, r7_tn, r7_td;

    always_comb begin
        n6_sd = r5_den;
        n6_td = r5_den;
        n6_sn = r5_sn;
        n6_tn = r5_tn;
        if (r5_den == '0) begin
            // parallel: s held at the start, t from e/c
            n6_sd = NW'(r5_c);
            n6_td = NW'(r5_c);
            n6_sn = '0;
            n6_tn = NW'(r5_e);
        end else if (r5_sn[NW-1]) begin
            n6_sn = '0;
            n6_tn = NW'(r5_e);
            n6_td = NW'(r5_c);
        end else if (r5_den < r5_sn) begin
            n6_sn = r5_den;
            n6_tn = NW'(r5_e) + NW'(r5_b);
            n6_td = NW'(r5_c);
        end
    end

    always_comb begin
        n7_sn = r6_sn;
        n7_sd = r6_sd;
        n7_tn = r6_tn;
        n7_td = r6_td;
        if (r6_tn[NW-1]) begin
            // t = 0 as 0/1, s recomputed against segment 2 start
            n7_tn = '0;
            n7_td = NW'(1);
            n7_sn = r6_nd;
            n7_sd = r6_a;
        end else if (r6_td < r6_tn) begin
            n7_tn = NW'(1);
            n7_td = NW'(1);
            n7_sn = r6_nbd;
            n7_sd = r6_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_ux     <= n1_ux;
            r1_uy     <= n1_uy;
            r1_vx     <= n1_vx;
            r1_vy     <= n1_vy;
            r1_wx     <= DW'(i_p0x) - DW'(i_q0x);
            r1_wy     <= DW'(i_p0y) - DW'(i_q0y);
            r_side[0] <= {i_p0x, i_p0y, n1_ux, n1_uy, i_q0x, i_q0y, n1_vx, n1_vy};
        end
        if (adv[1]) begin
            r2_uu_x   <= PW'(r1_ux) * PW'(r1_ux);
            r2_uu_y   <= PW'(r1_uy) * PW'(r1_uy);
            r2_uv_x   <= PW'(r1_ux) * PW'(r1_vx);
            r2_uv_y   <= PW'(r1_uy) * PW'(r1_vy);
            r2_vv_x   <= PW'(r1_vx) * PW'(r1_vx);
            r2_vv_y   <= PW'(r1_vy) * PW'(r1_vy);
            r2_uw_x   <= PW'(r1_ux) * PW'(r1_wx);
            r2_uw_y   <= PW'(r1_uy) * PW'(r1_wy);
            r2_vw_x   <= PW'(r1_vx) * PW'(r1_wx);
            r2_vw_y   <= PW'(r1_vy) * PW'(r1_wy);
            r_side[1] <= r_side[0];
        end
        if (adv[2]) begin
            r3_a      <= SW'(r2_uu_x) + SW'(r2_uu_y);
            r3_b      <= SW'(r2_uv_x) + SW'(r2_uv_y);
            r3_c      <= SW'(r2_vv_x) + SW'(r2_vv_y);
            r3_d      <= SW'(r2_uw_x) + SW'(r2_uw_y);
            r3_e      <= SW'(r2_vw_x) + SW'(r2_vw_y);
            r_side[2] <= r_side[1];
        end
        if (adv[3]) begin
            r4_ac     <= QW'(r3_a) * QW'(r3_c);
            r4_bb     <= QW'(r3_b) * QW'(r3_b);
            r4_be     <= QW'(r3_b) * QW'(r3_e);
            r4_cd     <= QW'(r3_c) * QW'(r3_d);
            r4_ae     <= QW'(r3_a) * QW'(r3_e);
            r4_bd     <= QW'(r3_b) * QW'(r3_d);
            r4_a      <= r3_a;
            r4_b      <= r3_b;
            r4_c      <= r3_c;
            r4_d      <= r3_d;
            r4_e      <= r3_e;
            r_side[3] <= r_side[2];
        end
        if (adv[4]) begin
            r5_den    <= NW'(r4_ac) - NW'(r4_bb);
            r5_sn     <= NW'(r4_be) - NW'(r4_cd);
            r5_tn     <= NW'(r4_ae) - NW'(r4_bd);
            r5_a      <= r4_a;
            r5_b      <= r4_b;
            r5_c      <= r4_c;
            r5_d      <= r4_d;
            r5_e      <= r4_e;
            r_side[4] <= r_side[3];
        end
        if (adv[5]) begin
            r6_sn     <= n6_sn;
            r6_sd     <= n6_sd;
            r6_tn     <= n6_tn;
            r6_td     <= n6_td;
            r6_nd     <= NW'(0) - NW'(r5_d);
            r6_nbd    <= NW'(r5_b) - NW'(r5_d);
            r6_a      <= NW'(r5_a);
            r_side[5] <= r_side[4];
        end
        if (adv[6]) begin
            r7_sn     <= n7_sn;
            r7_sd     <= n7_sd;
            r7_tn     <= n7_tn;
            r7_td     <= n7_td;
            r_side[6] <= r_side[5];
        end
    end

    assign o_sn     = r7_sn;
    assign o_sd     = r7_sd;
    assign o_tn     = r7_tn;
    assign o_td     = r7_td;
    assign o_side_s = r_side[NS-1][2*HW-1:HW];
    assign o_side_t = r_side[NS-1][HW-1:0];

endmodule

>>> rtl/spcp_div.sv
// ----------------------------------------------------------------------------
// spcp_div
// Pipelined restoring divider: n/m in Q1.FRAC_BITS, rounded half up,
// clamped to 0..1. One quotient bit per stage, with a sideband that follows.
// ----------------------------------------------------------------------------
module spcp_div #(
    parameter int unsigned NW        = 71,
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned SBW       = 66
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_adv_in,
    input  logic signed [NW-1:0] i_n,
    input  logic signed [NW-1:0] i_m,
    input  logic [SBW-1:0]       i_side,
    output logic                 o_valid,
    input  logic                 i_adv,
    output logic [FRAC_BITS:0]   o_q,
    output logic [SBW-1:0]       o_side
);
    import spcp_pkg::*;

    localparam int unsigned NI = FRAC_BITS + 1;   // quotient bits
    localparam int unsigned NS = NI + 2;          // precheck, bits, rounding

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    logic [NW-1:0]      r_rem  [0:NI];
    logic [NW-1:0]      r_m    [0:NI];
    logic [FRAC_BITS:0] r_q    [0:NI];
    logic               r_zero [0:NI];
    logic               r_one  [0:NI];
    logic [SBW-1:0]     r_side [0:NI];
    logic [FRAC_BITS:0] r_out_q;
    logic [SBW-1:0]     r_out_side;

    logic [NW-1:0]      n_sh   [1:NI];
    logic               n_ge   [1:NI];
    logic [FRAC_BITS+1:0] n_qinc;
    logic [FRAC_BITS:0]   n_out_q;
    logic                 n_zero;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_adv;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_adv_in = adv[0];
    assign o_valid  = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // non-positive operands give zero, n >= m gives one
    assign n_zero = i_n[NW-1] || (i_n == '0) || i_m[NW-1] || (i_m == '0);

    always_comb begin
        for (int k = 1; k <= NI; k++) begin
            n_sh[k] = {r_rem[k-1][NW-2:0], 1'b0};
            n_ge[k] = (n_sh[k] >= r_m[k-1]);
        end
        n_qinc = {1'b0, r_q[NI]} + (FRAC_BITS+2)'(1);
        if (r_zero[NI]) begin
            n_out_q = '0;
        end else if (r_one[NI]) begin
            n_out_q = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            n_out_q = n_qinc[FRAC_BITS+1:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_rem[0]  <= i_n;
            r_m[0]    <= i_m;
            r_q[0]    <= '0;
            r_zero[0] <= n_zero;
            r_one[0]  <= !n_zero && !(i_n < i_m);
            r_side[0] <= i_side;
        end
        for (int k = 1; k <= NI; k++) begin
            if (adv[k]) begin
                r_rem[k]  <= n_ge[k] ? (n_sh[k] - r_m[k-1]) : n_sh[k];
                r_m[k]    <= r_m[k-1];
                r_q[k]    <= {r_q[k-1][FRAC_BITS-1:0], n_ge[k]};
                r_zero[k] <= r_zero[k-1];
                r_one[k]  <= r_one[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
        if (adv[NS-1]) begin
            r_out_q    <= n_out_q;
            r_out_side <= r_side[NI];
        end
    end

    assign o_q    = r_out_q;
    assign o_side = r_out_side;

endmodule

>>> rtl/spcp_back.sv
// ----------------------------------------------------------------------------
// spcp_back
// Closest points from s and t, rounded points and rounded squared distance.
// Five register stages, the last one is the output register.
// ----------------------------------------------------------------------------
module spcp_back #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned FRAC_BITS  = 16,
    parameter int unsigned HW         = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_adv_in,
    input  logic [FRAC_BITS:0]           i_s,
    input  logic [FRAC_BITS:0]           i_t,
    input  logic [HW-1:0]                i_side_s,
    input  logic [HW-1:0]                i_side_t,
    output logic                         o_valid,
    input  logic                         i_adv,
    output logic [FRAC_BITS:0]           o_s,
    output logic [FRAC_BITS:0]           o_t,
    output logic signed [COORD_BITS-1:0] o_n1x,
    output logic signed [COORD_BITS-1:0] o_n1y,
    output logic signed [COORD_BITS-1:0] o_n2x,
    output logic signed [COORD_BITS-1:0] o_n2y,
    output logic [2*COORD_BITS:0]        o_dist
);
    import spcp_pkg::*;

    localparam int unsigned NS = 5;
    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned F  = FRAC_BITS;
    localparam int unsigned DW = C + 1;
    localparam int unsigned MW = C + F + 3;
    localparam int unsigned GW = C + F + 1;
    localparam int unsigned QW = 2 * GW + 1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_adv;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign o_adv_in = adv[0];
    assign o_valid  = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    logic signed [C-1:0]  n_p0x, n_p0y, n_q0x, n_q0y;
    logic signed [DW-1:0] n_ux, n_uy, n_vx, n_vy;

    always_comb begin
        {n_p0x, n_p0y, n_ux, n_uy} = i_side_s;
        {n_q0x, n_q0y, n_vx, n_vy} = i_side_t;
    end

    logic [F:0] r_s [0:NS-2];
    logic [F:0] r_t [0:NS-2];

    // stage 0: parameter times edge
    logic signed [MW-1:0] r0_sx, r0_sy, r0_tx, r0_ty;
    logic signed [C-1:0]  r0_p0x, r0_p0y, r0_q0x, r0_q0y;

    // stage 1: points in Q.F
    logic signed [MW-1:0] r1_f1x, r1_f1y, r1_f2x, r1_f2y;

    // stage 2: gap and rounded points
    logic signed [MW-1:0] n2_gx, n2_gy, n2_r1x, n2_r1y, n2_r2x, n2_r2y;
    logic signed [GW-1:0] r2_gx, r2_gy;
    logic signed [C-1:0]  r2_n1x, r2_n1y, r2_n2x, r2_n2y;

    // stage 3: squares
    logic [2*GW-1:0]      r3_qx, r3_qy;
    logic signed [C-1:0]  r3_n1x, r3_n1y, r3_n2x, r3_n2y;

    // stage 4: output
    logic [QW-1:0]        n4_sum;
    logic [2*C:0]         r4_dist;
    logic signed [C-1:0]  r4_n1x, r4_n1y, r4_n2x, r4_n2y;
    logic [F:0]           r4_s, r4_t;

    logic signed [MW-1:0] half_pt;
    assign half_pt = MW'(1) <<< (F - 1);

    always_comb begin
        n2_gx  = r1_f1x - r1_f2x;
        n2_gy  = r1_f1y - r1_f2y;
        n2_r1x = r1_f1x + half_pt;
        n2_r1y = r1_f1y + half_pt;
        n2_r2x = r1_f2x + half_pt;
        n2_r2y = r1_f2y + half_pt;
        n4_sum = QW'(r3_qx) + QW'(r3_qy) + (QW'(1) << (2 * F - 1));
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_sx  <= MW'($signed({1'b0, i_s})) * MW'(n_ux);
            r0_sy  <= MW'($signed({1'b0, i_s})) * MW'(n_uy);
            r0_tx  <= MW'($signed({1'b0, i_t})) * MW'(n_vx);
            r0_ty  <= MW'($signed({1'b0, i_t})) * MW'(n_vy);
            r0_p0x <= n_p0x;
            r0_p0y <= n_p0y;
            r0_q0x <= n_q0x;
            r0_q0y <= n_q0y;
            r_s[0] <= i_s;
            r_t[0] <= i_t;
        end
        if (adv[1]) begin
            r1_f1x <= (MW'(r0_p0x) <<< F) + r0_sx;
            r1_f1y <= (MW'(r0_p0y) <<< F) + r0_sy;
            r1_f2x <= (MW'(r0_q0x) <<< F) + r0_tx;
            r1_f2y <= (MW'(r0_q0y) <<< F) + r0_ty;
            r_s[1] <= r_s[0];
            r_t[1] <= r_t[0];
        end
        if (adv[2]) begin
            r2_gx  <= n2_gx[GW-1:0];
            r2_gy  <= n2_gy[GW-1:0];
            r2_n1x <= n2_r1x[F+C-1:F];
            r2_n1y <= n2_r1y[F+C-1:F];
            r2_n2x <= n2_r2x[F+C-1:F];
            r2_n2y <= n2_r2y[F+C-1:F];
            r_s[2] <= r_s[1];
            r_t[2] <= r_t[1];
        end
        if (adv[3]) begin
            r3_qx  <= r2_gx * r2_gx;
            r3_qy  <= r2_gy * r2_gy;
            r3_n1x <= r2_n1x;
            r3_n1y <= r2_n1y;
            r3_n2x <= r2_n2x;
            r3_n2y <= r2_n2y;
            r_s[3] <= r_s[2];
            r_t[3] <= r_t[2];
        end
        if (adv[4]) begin
            r4_dist <= n4_sum[2*F+2*C:2*F];
            r4_n1x  <= r3_n1x;
            r4_n1y  <= r3_n1y;
            r4_n2x  <= r3_n2x;
            r4_n2y  <= r3_n2y;
            r4_s    <= r_s[3];
            r4_t    <= r_t[3];
        end
    end

    assign o_s    = r4_s;
    assign o_t    = r4_t;
    assign o_n1x  = r4_n1x;
    assign o_n1y  = r4_n1y;
    assign o_n2x  = r4_n2x;
    assign o_n2y  = r4_n2y;
    assign o_dist = r4_dist;

endmodule
